### rtl/ipv4hb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 header builder package
// Shared types, register indexes, header constants and the one's-complement
// fold used by the payload accumulator and the header emitter.
// ----------------------------------------------------------------------------
package ipv4hb_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgSrcAddr  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgDstAddr  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSrcPort  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgDstPort  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgUseUdp   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgIdent    = 3'd5;
  localparam int unsigned CfgDataW = 32;

  // Header constants.
  localparam logic [15:0] IpVerIhl      = 16'h4500;
  localparam logic [7:0]  IpTtl         = 8'd64;
  localparam logic [7:0]  ProtoTcp      = 8'd6;
  localparam logic [7:0]  ProtoUdp      = 8'd17;
  localparam logic [15:0] TcpOffsetWord = 16'h5000;
  localparam logic [15:0] TcpWindow     = 16'hFFFF;
  localparam logic [16:0] IpHdrBytes    = 17'd20;
  localparam logic [16:0] TcpHdrBytes   = 17'd20;
  localparam logic [16:0] UdpHdrBytes   = 17'd8;
  localparam logic [15:0] MaxCount      = 16'hFFFF;

  // Index of the final header word for each transport.
  localparam int unsigned WordIdxW = 4;
  localparam logic [WordIdxW-1:0] UdpLastIdx = 4'd6;
  localparam logic [WordIdxW-1:0] TcpLastIdx = 4'd9;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        use_udp;
    logic [15:0] ident;
  } cfg_t;

  // Summary of one finished payload.
  typedef struct packed {
    logic [15:0] sum;
    logic [15:0] count;
    logic        overflow;
  } pkt_t;

  // End-around carry fold of a sum of up to sixteen 16-bit terms.
  function automatic logic [15:0] ones_fold(input logic [19:0] raw);
    logic [16:0] s1;
    logic [16:0] s2;
    s1 = {1'b0, raw[15:0]} + {13'd0, raw[19:16]};
    s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]};
    return s2[15:0];
  endfunction

endpackage

### rtl/ipv4hb_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 header builder payload accumulator
// Pairs payload bytes into big-endian 16-bit words, keeps the running
// one's-complement sum and a saturating byte count, and hands a packet
// summary to the emitter on the last byte.
// ----------------------------------------------------------------------------
module ipv4hb_accum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  logic [7:0]         s_tdata_i,
  input  logic               s_tlast_i,
  input  logic               take_i,
  output logic               pkt_valid_o,
  output ipv4hb_pkg::pkt_t   pkt_o
);

  logic [15:0]      sum_q, sum_d;
  logic [15:0]      count_q, count_d;
  logic [7:0]       pend_q, pend_d;
  logic             odd_q, odd_d;
  logic             ovf_q, ovf_d;
  logic             pkt_valid_q, pkt_valid_d;
  ipv4hb_pkg::pkt_t pkt_q, pkt_d;

  logic        accept;
  logic [15:0] word;
  logic [15:0] word_sum;
  logic [15:0] count_inc;
  logic        ovf_inc;

  // A finished summary blocks only the next last byte, never plain payload.
  assign s_tready_o = ~s_tlast_i | ~pkt_valid_q | take_i;
  assign accept     = s_tvalid_i & s_tready_o;

  // With no waiting high byte the new byte is padded with a zero low byte,
  // which only matters when it ends the packet.
  assign word      = odd_q ? {pend_q, s_tdata_i} : {s_tdata_i, 8'h00};
  assign word_sum  = ipv4hb_pkg::ones_fold({4'd0, sum_q} + {4'd0, word});
  assign ovf_inc   = ovf_q | (count_q == ipv4hb_pkg::MaxCount);
  assign count_inc = (count_q == ipv4hb_pkg::MaxCount) ? count_q : count_q + 16'd1;

  always_comb begin
    sum_d       = sum_q;
    count_d     = count_q;
    pend_d      = pend_q;
    odd_d       = odd_q;
    ovf_d       = ovf_q;
    pkt_d       = pkt_q;
    pkt_valid_d = pkt_valid_q & ~take_i;
    if (accept) begin
      if (s_tlast_i) begin
        sum_d          = '0;
        count_d        = '0;
        pend_d         = '0;
        odd_d          = 1'b0;
        ovf_d          = 1'b0;
        pkt_d.sum      = word_sum;
        pkt_d.count    = count_inc;
        pkt_d.overflow = ovf_inc;
        pkt_valid_d    = 1'b1;
      end else begin
        count_d = count_inc;
        ovf_d   = ovf_inc;
        if (odd_q) begin
          sum_d  = word_sum;
          pend_d = '0;
          odd_d  = 1'b0;
        end else begin
          pend_d = s_tdata_i;
          odd_d  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      count_q     <= '0;
      pend_q      <= '0;
      odd_q       <= 1'b0;
      ovf_q       <= 1'b0;
      pkt_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      odd_q       <= odd_d;
      ovf_q       <= ovf_d;
      pkt_valid_q <= pkt_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pkt_q <= pkt_d;
  end

  assign pkt_valid_o = pkt_valid_q;
  assign pkt_o       = pkt_q;

endmodule

### rtl/ipv4hb_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 header builder header emitter
// Computes lengths, error check and both checksums from a packet summary,
// then sends the header words one per handshake from an output register.
// ----------------------------------------------------------------------------
module ipv4hb_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ipv4hb_pkg::cfg_t   cfg_i,
  input  logic               pkt_valid_i,
  input  ipv4hb_pkg::pkt_t   pkt_i,
  output logic               take_o,
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output logic [31:0]        m_tdata_o,
  output logic               m_tlast_o,
  output logic               m_tuser_o
);

  logic                                busy_q, busy_d;
  logic                                err_q, err_d;
  logic [ipv4hb_pkg::WordIdxW-1:0]     idx_q, idx_d;
  logic [31:0]                         word_q, word_d;
  logic [15:0]                         ipsum_q, tlen_q, tsum_q;
  logic [7:0]                          proto_q;
  logic                                udp_q;

  // Checksum and length stage, fed straight from the summary register.
  logic [16:0] tlen_c, total_c;
  logic [7:0]  proto_c;
  logic        bad_c;
  logic [19:0] ip_raw, t_raw;
  logic [15:0] ipsum_c, tsum_inv, tsum_c;

  assign proto_c = cfg_i.use_udp ? ipv4hb_pkg::ProtoUdp : ipv4hb_pkg::ProtoTcp;
  assign tlen_c  = {1'b0, pkt_i.count} +
                   (cfg_i.use_udp ? ipv4hb_pkg::UdpHdrBytes : ipv4hb_pkg::TcpHdrBytes);
  assign total_c = tlen_c + ipv4hb_pkg::IpHdrBytes;
  assign bad_c   = (cfg_i.src_addr == '0) | (cfg_i.dst_addr == '0) |
                   (cfg_i.src_port == '0) | (cfg_i.dst_port == '0) |
                   pkt_i.overflow | total_c[16];

  assign ip_raw = {4'd0, ipv4hb_pkg::IpVerIhl} + {4'd0, total_c[15:0]} +
                  {4'd0, cfg_i.ident} + {4'd0, ipv4hb_pkg::IpTtl, proto_c} +
                  {4'd0, cfg_i.src_addr[31:16]} + {4'd0, cfg_i.src_addr[15:0]} +
                  {4'd0, cfg_i.dst_addr[31:16]} + {4'd0, cfg_i.dst_addr[15:0]};
  assign ipsum_c = ~ipv4hb_pkg::ones_fold(ip_raw);

  // Pseudo-header, transport header and payload sum in one adder tree.
  assign t_raw = {4'd0, pkt_i.sum} +
                 {4'd0, cfg_i.src_addr[31:16]} + {4'd0, cfg_i.src_addr[15:0]} +
                 {4'd0, cfg_i.dst_addr[31:16]} + {4'd0, cfg_i.dst_addr[15:0]} +
                 {12'd0, proto_c} + {4'd0, tlen_c[15:0]} +
                 {4'd0, cfg_i.src_port} + {4'd0, cfg_i.dst_port} +
                 (cfg_i.use_udp ? {4'd0, tlen_c[15:0]}
                                : ({4'd0, ipv4hb_pkg::TcpOffsetWord} +
                                   {4'd0, ipv4hb_pkg::TcpWindow}));
  assign tsum_inv = ~ipv4hb_pkg::ones_fold(t_raw);
  // A UDP checksum of zero means "none", so it goes out as all ones.
  assign tsum_c   = (cfg_i.use_udp && tsum_inv == '0) ? 16'hFFFF : tsum_inv;

  // Word sequencing.
  logic                            word_last;
  logic                            fire;
  logic [ipv4hb_pkg::WordIdxW-1:0] idx_next;
  logic [31:0]                     word_next;

  assign word_last = err_q |
                     (idx_q == (udp_q ? ipv4hb_pkg::UdpLastIdx : ipv4hb_pkg::TcpLastIdx));
  assign fire      = busy_q & m_tready_i;
  assign take_o    = pkt_valid_i & (~busy_q | (fire & word_last));
  assign idx_next  = idx_q + 1'b1;

  always_comb begin
    case (idx_next)
      4'd1:    word_next = {cfg_i.ident, 16'h0000};
      4'd2:    word_next = {ipv4hb_pkg::IpTtl, proto_q, ipsum_q};
      4'd3:    word_next = cfg_i.src_addr;
      4'd4:    word_next = cfg_i.dst_addr;
      4'd5:    word_next = {cfg_i.src_port, cfg_i.dst_port};
      4'd6:    word_next = udp_q ? {tlen_q, tsum_q} : 32'h0;
      4'd7:    word_next = 32'h0;
      4'd8:    word_next = {ipv4hb_pkg::TcpOffsetWord, ipv4hb_pkg::TcpWindow};
      4'd9:    word_next = {tsum_q, 16'h0000};
      default: word_next = 32'h0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    err_d  = err_q;
    idx_d  = idx_q;
    word_d = word_q;
    if (take_o) begin
      busy_d = 1'b1;
      err_d  = bad_c;
      idx_d  = '0;
      word_d = bad_c ? 32'h0 : {ipv4hb_pkg::IpVerIhl, total_c[15:0]};
    end else if (fire) begin
      if (word_last) begin
        busy_d = 1'b0;
      end else begin
        idx_d  = idx_next;
        word_d = word_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      err_q  <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      err_q  <= err_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    if (take_o) begin
      tlen_q  <= tlen_c[15:0];
      ipsum_q <= ipsum_c;
      tsum_q  <= tsum_c;
      proto_q <= proto_c;
      udp_q   <= cfg_i.use_udp;
    end
  end

  assign m_tvalid_o = busy_q;
  assign m_tdata_o  = word_q;
  assign m_tlast_o  = word_last;
  assign m_tuser_o  = err_q;

endmodule

### rtl/ipv4_tcp_udp_header_builder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 TCP/UDP header builder
// Sums payload bytes and emits an IPv4 plus TCP or UDP header with checksums.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one payload byte per word (tdata) with tlast on the
// final byte. Non-final bytes are taken every cycle and produce no output.
// The master stream carries 32-bit header words, first byte in bits 31..24:
// five IPv4 words followed by five TCP words or two UDP words, tlast on the
// final one. A rejected packet (zero address or port, or a total length above
// 65535) gives a single word of zero with tlast and tuser both high.
// The edge that takes the last byte loads the summary register; the first
// header word enters the output register once the emitter is free. Bytes
// are taken at one byte per cycle while tready is high; a header leaves at
// one word per cycle while the receiver is ready, 7 or 10 words, from the
// single output register of the emitter. A last byte waits (tready low)
// only while a previous packet's summary is still waiting behind a header
// in flight; other bytes always flow. A stalled receiver simply holds the
// current word. Reset clears the packet state and all configuration registers
// to zero. Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i;
// the user must do so only while no header is pending; this is not enforced.
// ----------------------------------------------------------------------------
module ipv4_tcp_udp_header_builder_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [ipv4hb_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ipv4hb_pkg::CfgDataW-1:0]   cfg_data_i,
  // Payload byte stream.
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  input  logic [7:0]                        s_tdata_i,   // [7:0] payload_byte
  input  logic                              s_tlast_i,   // last_byte
  // Header word stream.
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  output logic [31:0]                       m_tdata_o,   // [31:0] header_word
  output logic                              m_tlast_o,   // last_word
  output logic                              m_tuser_o    // [0] error_flag
);

  ipv4hb_pkg::cfg_t cfg_q, cfg_d;
  ipv4hb_pkg::pkt_t pkt;
  logic             pkt_valid;
  logic             take;

  // Configuration registers; a write to an unused index is ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        ipv4hb_pkg::CfgSrcAddr: cfg_d.src_addr = cfg_data_i;
        ipv4hb_pkg::CfgDstAddr: cfg_d.dst_addr = cfg_data_i;
        ipv4hb_pkg::CfgSrcPort: cfg_d.src_port = cfg_data_i[15:0];
        ipv4hb_pkg::CfgDstPort: cfg_d.dst_port = cfg_data_i[15:0];
        ipv4hb_pkg::CfgUseUdp:  cfg_d.use_udp  = cfg_data_i[0];
        ipv4hb_pkg::CfgIdent:   cfg_d.ident    = cfg_data_i[15:0];
        default:                cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Byte pairing, running sum and count; one summary register per packet.
  ipv4hb_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tlast_i   (s_tlast_i),
    .take_i      (take),
    .pkt_valid_o (pkt_valid),
    .pkt_o       (pkt)
  );

  // Checksums and header words, sent from the output register.
  ipv4hb_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pkt_valid_i (pkt_valid),
    .pkt_i       (pkt),
    .take_o      (take),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tlast_o   (m_tlast_o),
    .m_tuser_o   (m_tuser_o)
  );

endmodule
